// ===== rtl/rld_pkg.sv =====
package rld_pkg;

  // Field and datapath widths.
  localparam int DIGIT_W = 4;
  localparam int LEN_W   = 31;
  localparam int DIV_W   = 16;
  localparam int VAL_W   = 30;
  localparam int QUOT_W  = 14;

  // Number of run-length bits that the scan can ever look at.
  localparam int LEN_BITS = 31;

  typedef logic [VAL_W-1:0] val_t;

  localparam val_t PRIME_FACTOR = 30'd10007;
  localparam val_t RADIX        = 30'd10;

  // One table row: R(2^i) mod M and 10^(2^i) mod M.
  typedef struct packed {
    val_t rep;
    val_t pow;
  } tbl_entry_t;

endpackage

// ===== rtl/rld_table_mem.sv =====
module rld_table_mem #(
  parameter int DEPTH = 31,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  rld_pkg::tbl_entry_t wdata,
  input  logic [AW-1:0]       raddr,
  output rld_pkg::tbl_entry_t rdata
);

  rld_pkg::tbl_entry_t mem [DEPTH];
  rld_pkg::tbl_entry_t rdata_r;

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rld_modmul.sv =====
module rld_modmul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rld_pkg::val_t a,
  input  rld_pkg::val_t b,
  input  rld_pkg::val_t m,
  output logic          done,
  output rld_pkg::val_t prod
);

  // Interleaved shift-and-add reduction, one multiplier bit per cycle,
  // most significant bit first. The multiplicand must be below m; the
  // multiplier may take any value of its width.
  localparam int T_W   = rld_pkg::VAL_W + 2;
  localparam int CNT_W = $clog2(rld_pkg::VAL_W + 1);

  rld_pkg::val_t acc_r, acc_nxt;
  rld_pkg::val_t a_r;
  rld_pkg::val_t b_r;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r;
  logic done_r;

  logic [T_W-1:0] t;
  logic [T_W-1:0] m1;
  logic [T_W-1:0] m2;

  always_comb begin
    m1 = T_W'(m);
    m2 = {1'b0, m, 1'b0};
    t  = {1'b0, acc_r, 1'b0} + (b_r[rld_pkg::VAL_W-1] ? T_W'(a_r) : '0);
    if (t >= m2) begin
      acc_nxt = rld_pkg::VAL_W'(t - m2);
    end else if (t >= m1) begin
      acc_nxt = rld_pkg::VAL_W'(t - m1);
    end else begin
      acc_nxt = rld_pkg::VAL_W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(rld_pkg::VAL_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNT_W'(1));
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[rld_pkg::VAL_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/rld_qdiv.sv =====
module rld_qdiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  rld_pkg::val_t               num,
  input  logic [rld_pkg::DIV_W-1:0]   den,
  output logic                        done,
  output logic [rld_pkg::QUOT_W-1:0]  quot
);

  // Restoring division, one quotient bit per cycle. The dividend is known to
  // be below PRIME_FACTOR times the divisor, so the quotient fits QUOT_W bits.
  localparam int CNT_W = $clog2(rld_pkg::QUOT_W + 1);

  rld_pkg::val_t rem_r;
  rld_pkg::val_t dv_r;
  logic [rld_pkg::QUOT_W-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r;
  logic done_r;
  logic ge;

  assign ge = (rem_r >= dv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(rld_pkg::QUOT_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNT_W'(1));
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dv_r  <= rld_pkg::VAL_W'(den) << (rld_pkg::QUOT_W - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dv_r;
      end
      q_r  <= {q_r[rld_pkg::QUOT_W-2:0], ge};
      dv_r <= dv_r >> 1;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/run_length_decimal_modulo.sv =====
// Run-length decimal remainder engine.
// A decimal number arrives most significant part first on the in_ stream, one
// run (digit, run length) per transfer; in_tuser set clears the running
// remainder before that run. Every run answers with one transfer on the out_
// stream carrying the remainder modulo M = 10007 * divisor and the quotient
// floor(remainder / divisor). The divisor is written through cfg_we/cfg_wdata
// (zero is taken as one); each write rebuilds the tables of 10^(2^i) mod M and
// R(2^i) mod M held in the table memory.
// The work per run grows with the number of set bits in the run length, and the
// next run is taken only once the result of the last has been loaded. The cost is
// set by the two bit-serial modular multipliers (both running side by side), the
// scan step per length bit, the table read per set bit and the divider.
// in_tready is low during the table rebuild after reset or a divisor write.
// Reset clears the remainder, sets the divisor to one and starts a rebuild.
// A finished result waits in the output register while the receiver stalls;
// the next run is accepted meanwhile and is held before its result is loaded
// until the waiting transfer has completed.
module run_length_decimal_modulo #(
  parameter int TABLE_DEPTH = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // digit[3:0], run_length[34:4], zero fill
  input  logic        in_tuser,   // start_req
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // remainder_mod[29:0], quotient_mod[43:30], zero fill
  // Configuration.
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  // Only this many run-length bits have table rows behind them.
  localparam int SCAN_LIMIT = (TABLE_DEPTH < rld_pkg::LEN_BITS) ? TABLE_DEPTH
                                                                : rld_pkg::LEN_BITS;

  typedef enum logic [9:0] {
    S_BINIT  = 10'b0000000001,
    S_BSTART = 10'b0000000010,
    S_BMUL   = 10'b0000000100,
    S_IDLE   = 10'b0000001000,
    S_SCAN   = 10'b0000010000,
    S_BITRD  = 10'b0000100000,
    S_BITMUL = 10'b0001000000,
    S_FINMUL = 10'b0010000000,
    S_DIV    = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  // Sum of two residues, both below m.
  function automatic rld_pkg::val_t addmod(input rld_pkg::val_t x, input rld_pkg::val_t y,
                                           input rld_pkg::val_t m);
    logic [rld_pkg::VAL_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return rld_pkg::VAL_W'(s);
  endfunction

  state_t state_r, state_nxt;
  logic [rld_pkg::DIV_W-1:0] divisor_r, divisor_nxt;
  rld_pkg::val_t m_r, m_nxt;
  rld_pkg::val_t rem_r, rem_nxt;
  rld_pkg::val_t pw_r, pw_nxt;
  rld_pkg::val_t rep_r, rep_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [rld_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [rld_pkg::DIGIT_W-1:0] digit_r, digit_nxt;
  logic out_valid_r, out_valid_nxt;
  rld_pkg::val_t out_rem_r;
  logic [rld_pkg::QUOT_W-1:0] out_quot_r;

  logic [rld_pkg::DIV_W-1:0] cfg_div;
  logic in_xfer;
  logic out_load;
  logic scan_end;

  // Table memory signals.
  logic mem_we;
  logic [IW-1:0] mem_waddr;
  rld_pkg::tbl_entry_t mem_wdata;
  rld_pkg::tbl_entry_t mem_rdata;

  // Multiplier signals. Unit A and unit B always start together.
  logic mm_start;
  rld_pkg::val_t mm_a_a, mm_b_a, mm_a_b, mm_b_b;
  logic mm_done_a, mm_done_b;
  rld_pkg::val_t mm_prod_a, mm_prod_b;

  // Divider signals.
  logic div_start;
  rld_pkg::val_t div_num;
  logic div_done;
  logic [rld_pkg::QUOT_W-1:0] div_quot;

  assign cfg_div  = (cfg_wdata == '0) ? rld_pkg::DIV_W'(1) : cfg_wdata;
  assign in_tready = (state_r == S_IDLE) && !cfg_we;
  assign in_xfer  = in_tvalid && in_tready;
  assign scan_end = (idx_r == CW'(SCAN_LIMIT));
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready) && !cfg_we;

  // Operand selection. During a rebuild the units square the power and
  // extend the repunit; per set length bit they fold in one table row; at the
  // end of the scan they form rem * 10^L and digit * R(L).
  always_comb begin
    if (state_r == S_BSTART) begin
      mm_a_a = pw_r;
      mm_b_a = pw_r;
      mm_a_b = rep_r;
      mm_b_b = addmod(pw_r, rld_pkg::VAL_W'(1), m_r);
    end else if (state_r == S_BITRD) begin
      mm_a_a = pw_r;
      mm_b_a = mem_rdata.rep;
      mm_a_b = pw_r;
      mm_b_b = mem_rdata.pow;
    end else begin
      mm_a_a = pw_r;
      mm_b_a = rem_r;
      mm_a_b = rep_r;
      mm_b_b = rld_pkg::VAL_W'(digit_r);
    end
  end

  assign mm_start = (state_r == S_BSTART) || (state_r == S_BITRD)
                  || ((state_r == S_SCAN) && scan_end);

  assign mem_we = (state_r == S_BINIT) || ((state_r == S_BMUL) && mm_done_a);
  // Row zero is written on entry to the rebuild, whatever the index holds.
  assign mem_waddr = (state_r == S_BINIT) ? '0 : idx_r[IW-1:0];
  always_comb begin
    if (state_r == S_BINIT) begin
      mem_wdata.rep = rld_pkg::VAL_W'(1);
      mem_wdata.pow = rld_pkg::RADIX;
    end else begin
      mem_wdata.rep = mm_prod_b;
      mem_wdata.pow = mm_prod_a;
    end
  end

  assign div_num   = addmod(mm_prod_a, mm_prod_b, m_r);
  assign div_start = (state_r == S_FINMUL) && mm_done_a;

  always_comb begin
    state_nxt     = state_r;
    divisor_nxt   = divisor_r;
    m_nxt         = m_r;
    rem_nxt       = rem_r;
    pw_nxt        = pw_r;
    rep_nxt       = rep_r;
    idx_nxt       = idx_r;
    len_nxt       = len_r;
    digit_nxt     = digit_r;
    out_valid_nxt = out_valid_r;

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_BINIT: begin
        // Row zero: 10 and 1 are already below any modulus.
        pw_nxt    = rld_pkg::RADIX;
        rep_nxt   = rld_pkg::VAL_W'(1);
        idx_nxt   = CW'(1);
        state_nxt = S_BSTART;
      end
      S_BSTART: begin
        state_nxt = S_BMUL;
      end
      S_BMUL: begin
        if (mm_done_a) begin
          pw_nxt  = mm_prod_a;
          rep_nxt = mm_prod_b;
          if (idx_r == CW'(TABLE_DEPTH - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_BSTART;
          end
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          digit_nxt = in_tdata[3:0];
          len_nxt   = in_tdata[34:4];
          if (in_tuser) begin
            rem_nxt = '0;
          end
          pw_nxt    = rld_pkg::VAL_W'(1);
          rep_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_FINMUL;
        end else if (len_r[0]) begin
          state_nxt = S_BITRD;
        end else begin
          idx_nxt = idx_r + 1'b1;
          len_nxt = len_r >> 1;
        end
      end
      S_BITRD: begin
        state_nxt = S_BITMUL;
      end
      S_BITMUL: begin
        if (mm_done_a) begin
          rep_nxt   = addmod(rep_r, mm_prod_a, m_r);
          pw_nxt    = mm_prod_b;
          idx_nxt   = idx_r + 1'b1;
          len_nxt   = len_r >> 1;
          state_nxt = S_SCAN;
        end
      end
      S_FINMUL: begin
        if (mm_done_a) begin
          rem_nxt   = div_num;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_BINIT;
      end
    endcase

    // A divisor write restarts the rebuild whatever is going on.
    if (cfg_we) begin
      divisor_nxt = cfg_div;
      m_nxt       = rld_pkg::VAL_W'(rld_pkg::VAL_W'(cfg_div) * rld_pkg::PRIME_FACTOR);
      state_nxt   = S_BINIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BINIT;
      divisor_r   <= rld_pkg::DIV_W'(1);
      m_r         <= rld_pkg::PRIME_FACTOR;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      divisor_r   <= divisor_nxt;
      m_r         <= m_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pw_r    <= pw_nxt;
    rep_r   <= rep_nxt;
    idx_r   <= idx_nxt;
    len_r   <= len_nxt;
    digit_r <= digit_nxt;
    if (out_load) begin
      out_rem_r  <= rem_r;
      out_quot_r <= div_quot;
    end
  end

  rld_table_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r[IW-1:0]),
    .rdata (mem_rdata)
  );

  rld_modmul u_mm_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .a     (mm_a_a),
    .b     (mm_b_a),
    .m     (m_r),
    .done  (mm_done_a),
    .prod  (mm_prod_a)
  );

  rld_modmul u_mm_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .a     (mm_a_b),
    .b     (mm_b_b),
    .m     (m_r),
    .done  (mm_done_b),
    .prod  (mm_prod_b)
  );

  rld_qdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (divisor_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_quot_r, out_rem_r};

  // The two multipliers share one start and must finish in the same cycle.
  a_mm_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done_a == mm_done_b)
    else $error("multiplier units out of step");

  // A divisor write blocks new runs while the tables are rebuilt.
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input accepted during table rebuild");

  // The remainder is always reduced, so the quotient stays below 10007.
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rld_pkg::VAL_W'(out_quot_r) < rld_pkg::PRIME_FACTOR))
    else $error("quotient out of range");

  // A result only appears after its run has passed through the hand-off state.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the hand-off state");

endmodule
